### src/mask_boundary_overlay_assert.svh
// Assertion macros for the mask boundary overlay block.
// Used by mask_boundary_overlay.sv; no other dependencies.
`ifndef MASK_BOUNDARY_OVERLAY_ASSERT_SVH
`define MASK_BOUNDARY_OVERLAY_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MBO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MBO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mbo_pkg.sv
// Shared types and constants for the mask boundary overlay block.
// No dependencies; used by the interfaces and the top level.
package mbo_pkg;

    localparam int FUNC_W   = 1;
    localparam int MASK_W   = 8;
    localparam int COLOR_W  = 32;
    localparam int COORD_W  = 13;
    localparam int OFS_W    = 12;
    localparam int FCOLS_W  = 11;
    localparam int FROWS_W  = 13;
    localparam int ROW_W    = 13;
    localparam int RCOORD_W = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FROWS_W-1:0] ROWS_LIMIT = 13'd4096;

    localparam logic [FCOLS_W-1:0] FRAME_COLS_RST = 11'd1024;
    localparam logic [FROWS_W-1:0] FRAME_ROWS_RST = 13'd1024;

    // Request kinds on the pixel channel
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PIXEL = 1'b0,
        FUNC_FLUSH = 1'b1
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COLS    = 3'd0,
        REG_FRAME_ROWS    = 3'd1,
        REG_X_OFFSET      = 3'd2,
        REG_Y_OFFSET      = 3'd3,
        REG_FILL_MODE     = 3'd4,
        REG_OVERLAY_COLOR = 3'd5
    } cfg_reg_t;

endpackage

### src/mbo_if.sv
// Channel interfaces for the mask boundary overlay block: pixel requests,
// overlay results and configuration writes. Depends on mbo_pkg.
interface mbo_pix_if;
    logic                       valid;
    logic                       ready;
    logic [mbo_pkg::FUNC_W-1:0] func;
    logic [mbo_pkg::MASK_W-1:0] mask_value;

    modport source (output valid, func, mask_value, input ready);
    modport sink   (input valid, func, mask_value, output ready);
endinterface

interface mbo_res_if;
    logic                        valid;
    logic                        ready;
    logic                        paint;
    logic [mbo_pkg::COLOR_W-1:0] pixel_color;
    logic [mbo_pkg::COORD_W-1:0] out_x;
    logic [mbo_pkg::COORD_W-1:0] out_y;
    logic                        frame_end;

    modport source (output valid, paint, pixel_color, out_x, out_y, frame_end, input ready);
    modport sink   (input valid, paint, pixel_color, out_x, out_y, frame_end, output ready);
endinterface

interface mbo_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbo_pkg::CFG_IDX_W-1:0]  index;
    logic [mbo_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/mask_boundary_overlay.sv
// Top level of the mask boundary overlay: two-row line memories, 4-neighbor
// boundary test and output register. Depends on mbo_pkg, mbo_if.sv and
// mask_boundary_overlay_assert.svh.
//
//  channel | modport | carries
//  --------+---------+------------------------------------------------
//  pixel   | sink    | func, mask_value
//  result  | source  | paint, pixel_color, out_x, out_y, frame_end
//  cfg     | sink    | index, data (always ready)
//
// One pixel request per clock while pixel.ready is high; a result passes through
// the line memory read stage and then the output register.
// The row store is two single-port-read memories of MAX_COLS bits, one per
// row parity; no clearing pass, entries are defined once written.
// Reset clears positions and sets configuration to its reset values; memory contents stay.
// pixel.ready drops only while the read stage and the output register both
// hold results and result.ready is low.

`include "mask_boundary_overlay_assert.svh"

module mask_boundary_overlay #(
    parameter int MAX_COLS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    mbo_pix_if.sink           pixel,
    mbo_res_if.source         result,
    mbo_cfg_if.sink           cfg
);

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W = $clog2(MAX_COLS + 1);
    localparam logic [CNT_W-1:0] MAX_COLS_CNT = CNT_W'(MAX_COLS);

    // Read-stage request fields
    typedef struct packed {
        logic [COL_W-1:0]            col;
        logic [mbo_pkg::RCOORD_W-1:0] row;
        logic                        col_zero;
        logic                        has_right;
        logic                        up_center;
        logic                        down_center;
        logic                        down_bit;
        logic                        last;
        logic                        win_slot;
        logic                        col0_val;
    } rd_req_t;

    // Configuration registers
    logic [mbo_pkg::FCOLS_W-1:0]  frame_cols_reg;
    logic [mbo_pkg::FROWS_W-1:0]  frame_rows_reg;
    logic [mbo_pkg::OFS_W-1:0]    x_offset_reg;
    logic [mbo_pkg::OFS_W-1:0]    y_offset_reg;
    logic                         fill_mode_reg;
    logic [mbo_pkg::COLOR_W-1:0]  overlay_color_reg;

    // Position state
    logic [COL_W-1:0]            in_col_reg, in_col_next;
    logic [mbo_pkg::ROW_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]            flush_col_reg, flush_col_next;

    // Line memories, column-zero copies and registered read data
    logic                        line0_mem [MAX_COLS];
    logic                        line1_mem [MAX_COLS];
    logic                        col0_reg [2];
    logic                        rd0_reg;
    logic                        rd1_reg;

    // Read stage, window and output register
    logic                        s1_valid_reg, s1_valid_next;
    rd_req_t                     s1_reg, s1_next;
    logic                        win_c_reg;
    logic                        win_n_reg;
    logic                        out_valid_reg;
    logic                        out_paint_reg;
    logic [mbo_pkg::COLOR_W-1:0] out_color_reg;
    logic [mbo_pkg::COORD_W-1:0] out_x_reg;
    logic [mbo_pkg::COORD_W-1:0] out_y_reg;
    logic                        out_end_reg;

    // Request-stage signals
    logic                        pix_fire;
    logic                        out_free;
    logic                        s1_go;
    logic [CNT_W-1:0]            cols_eff;
    logic [mbo_pkg::FROWS_W-1:0] rows_eff;
    logic [mbo_pkg::FROWS_W-1:0] lrow;
    logic [mbo_pkg::ROW_W-1:0]   prow;
    logic                        is_flush;
    logic                        complete;
    logic [COL_W-1:0]            mcol;
    logic [COL_W-1:0]            fcol;
    logic [COL_W-1:0]            col_sel;
    logic [CNT_W-1:0]            col_inc;
    logic                        is_last_col;
    logic                        in_bit;
    logic                        mask_go;
    logic                        flush_go;
    logic                        emit;
    logic                        win_slot;
    logic [COL_W-1:0]            addr0;
    logic [COL_W-1:0]            addr1;

    // Read-stage signals
    logic                        rd_win;
    logic                        rd_up;
    logic                        center;
    logic                        left_bit;
    logic                        right_bit;
    logic                        up_bit;
    logic                        down_bit;
    logic                        paint;

    // Handshakes
    assign pix_fire    = pixel.valid && pixel.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign s1_go       = s1_valid_reg && out_free;
    assign pixel.ready = !s1_valid_reg || out_free;
    assign cfg.ready   = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cols_reg    <= mbo_pkg::FRAME_COLS_RST;
            frame_rows_reg    <= mbo_pkg::FRAME_ROWS_RST;
            x_offset_reg      <= '0;
            y_offset_reg      <= '0;
            fill_mode_reg     <= 1'b0;
            overlay_color_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                mbo_pkg::REG_FRAME_COLS:    frame_cols_reg    <= cfg.data[mbo_pkg::FCOLS_W-1:0];
                mbo_pkg::REG_FRAME_ROWS:    frame_rows_reg    <= cfg.data[mbo_pkg::FROWS_W-1:0];
                mbo_pkg::REG_X_OFFSET:      x_offset_reg      <= cfg.data[mbo_pkg::OFS_W-1:0];
                mbo_pkg::REG_Y_OFFSET:      y_offset_reg      <= cfg.data[mbo_pkg::OFS_W-1:0];
                mbo_pkg::REG_FILL_MODE:     fill_mode_reg     <= cfg.data[0];
                mbo_pkg::REG_OVERLAY_COLOR: overlay_color_reg <= cfg.data[mbo_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp frame size to the supported range
    always_comb
    begin
        if (frame_cols_reg == '0)
            cols_eff = CNT_W'(1);
        else if (32'(frame_cols_reg) > MAX_COLS)
            cols_eff = MAX_COLS_CNT;
        else
            cols_eff = CNT_W'(frame_cols_reg);

        if (frame_rows_reg == '0)
            rows_eff = mbo_pkg::FROWS_W'(1);
        else if (frame_rows_reg > mbo_pkg::ROWS_LIMIT)
            rows_eff = mbo_pkg::ROWS_LIMIT;
        else
            rows_eff = frame_rows_reg;
    end

    // Decode the request and pick column, row and memory slots
    always_comb
    begin
        is_flush    = (pixel.func == mbo_pkg::FUNC_FLUSH);
        complete    = (in_row_reg >= rows_eff);
        mcol        = (CNT_W'(in_col_reg) >= cols_eff) ? '0 : in_col_reg;
        fcol        = (CNT_W'(flush_col_reg) >= cols_eff) ? '0 : flush_col_reg;
        col_sel     = is_flush ? fcol : mcol;
        col_inc     = CNT_W'(col_sel) + CNT_W'(1);
        is_last_col = (col_inc >= cols_eff);
        in_bit      = |pixel.mask_value;
        lrow        = rows_eff - mbo_pkg::FROWS_W'(1);
        prow        = in_row_reg - mbo_pkg::ROW_W'(1);
        mask_go     = pix_fire && !is_flush && !complete;
        flush_go    = pix_fire && is_flush && complete;
        emit        = (mask_go && (in_row_reg != '0)) || flush_go;
        win_slot    = is_flush ? lrow[0] : ~in_row_reg[0];

        // window row reads one column ahead, the other row at the column
        addr0 = win_slot ? col_sel : col_inc[COL_W-1:0];
        addr1 = win_slot ? col_inc[COL_W-1:0] : col_sel;

        s1_next.col         = col_sel;
        s1_next.row         = is_flush ? lrow[mbo_pkg::RCOORD_W-1:0]
                                       : prow[mbo_pkg::RCOORD_W-1:0];
        s1_next.col_zero    = (col_sel == '0);
        s1_next.has_right   = !is_last_col;
        s1_next.up_center   = is_flush ? (lrow == '0) : (in_row_reg == mbo_pkg::ROW_W'(1));
        s1_next.down_center = is_flush;
        s1_next.down_bit    = in_bit;
        s1_next.last        = is_flush && is_last_col;
        s1_next.win_slot    = win_slot;
        s1_next.col0_val    = col0_reg[win_slot];
    end

    // Advance the stream position
    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        flush_col_next = flush_col_reg;
        if (mask_go)
        begin
            if (is_last_col)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + mbo_pkg::ROW_W'(1);
            end
            else
            begin
                in_col_next = col_inc[COL_W-1:0];
            end
        end
        else if (flush_go)
        begin
            if (is_last_col)
            begin
                in_col_next    = '0;
                in_row_next    = '0;
                flush_col_next = '0;
            end
            else
            begin
                flush_col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            flush_col_reg <= '0;
        end
        else
        begin
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            flush_col_reg <= flush_col_next;
        end
    end

    // Line memory for even rows: read old data, then store the new bit
    always_ff @(posedge clk)
    begin
        if (emit)
            rd0_reg <= line0_mem[addr0];
        if (mask_go && !in_row_reg[0])
            line0_mem[col_sel] <= in_bit;
    end

    // Line memory for odd rows
    always_ff @(posedge clk)
    begin
        if (emit)
            rd1_reg <= line1_mem[addr1];
        if (mask_go && in_row_reg[0])
            line1_mem[col_sel] <= in_bit;
    end

    // Keep a copy of column zero of each row slot
    always_ff @(posedge clk)
    begin
        if (mask_go && (col_sel == '0))
            col0_reg[in_row_reg[0]] <= in_bit;
    end

    // Read stage occupancy
    always_comb
    begin
        if (emit)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    // Hold the request fields for the read stage
    always_ff @(posedge clk)
    begin
        if (emit)
            s1_reg <= s1_next;
    end

    // Gather the 4-neighborhood and decide paint
    always_comb
    begin
        rd_win    = s1_reg.win_slot ? rd1_reg : rd0_reg;
        rd_up     = s1_reg.win_slot ? rd0_reg : rd1_reg;
        center    = s1_reg.col_zero ? s1_reg.col0_val : win_n_reg;
        left_bit  = s1_reg.col_zero ? center : win_c_reg;
        right_bit = s1_reg.has_right ? rd_win : center;
        up_bit    = s1_reg.up_center ? center : rd_up;
        down_bit  = s1_reg.down_center ? center : s1_reg.down_bit;
        paint     = center && (fill_mode_reg || !up_bit || !down_bit || !left_bit || !right_bit);
    end

    // Slide the window along the output row
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            win_c_reg <= center;
            win_n_reg <= rd_win;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_paint_reg <= paint;
            out_color_reg <= overlay_color_reg;
            out_x_reg     <= mbo_pkg::COORD_W'(s1_reg.col) + mbo_pkg::COORD_W'(x_offset_reg);
            out_y_reg     <= mbo_pkg::COORD_W'(s1_reg.row) + mbo_pkg::COORD_W'(y_offset_reg);
            out_end_reg   <= s1_reg.last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.paint       = out_paint_reg;
    assign result.pixel_color = out_color_reg;
    assign result.out_x       = out_x_reg;
    assign result.out_y       = out_y_reg;
    assign result.frame_end   = out_end_reg;

    // Checks
    `MBO_ASSERT_NOW(a_no_accept_when_full, clk, rst_n, s1_valid_reg && out_valid_reg && !result.ready, !pixel.ready, "pixel accepted while both stages are full")
    `MBO_ASSERT_NEXT(a_stalled_stage_holds, clk, rst_n, s1_valid_reg && !s1_go, s1_valid_reg, "read stage dropped a stalled request")
    `MBO_ASSERT_NEXT(a_last_flush_rewinds, clk, rst_n, flush_go && is_last_col, (in_row_reg == '0) && (in_col_reg == '0) && (flush_col_reg == '0), "frame did not rewind after last flush")
    `MBO_ASSERT_NOW(a_row_in_range, clk, rst_n, 1'b1, in_row_reg <= mbo_pkg::ROWS_LIMIT, "row position beyond row limit")

endmodule
